// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker file of the formatter.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define DNF_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("dnf check failed");

// Check a property on every rising clock edge, reset included.
`define DNF_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dnf check failed during reset");

`endif

// ===== hdl/dnf_pkg.sv =====
// Shared constants, codes and stage types of the display number formatter.
// Depends on nothing; every other file but assert_macros.svh imports it.
`timescale 1ns / 1ps
`default_nettype none

package dnf_pkg;

  localparam int MAG_W    = 30;          // magnitude width, thousandths
  localparam int MODE_W   = 3;
  localparam int DIGITS   = 9;           // BCD digits of an in-range magnitude
  localparam int BCD_W    = DIGITS * 4;
  localparam int SHOWN    = 6;           // digits left after rounding
  localparam int FIELD    = 7;           // characters in the widest field
  localparam int CHAR_W   = 8;
  localparam int LEN_W    = 3;

  // Decimals mode codes
  localparam logic [MODE_W-1:0] MODE_DEC0 = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DEC1 = 3'd1;
  localparam logic [MODE_W-1:0] MODE_DEC2 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_DEC3 = 3'd3;
  localparam logic [MODE_W-1:0] MODE_AUTO = 3'd4;

  // Largest unrounded magnitude shown with 0..3 decimals
  localparam logic [MAG_W-1:0] LIMIT_DEC0 = 30'd999999000;
  localparam logic [MAG_W-1:0] LIMIT_DEC1 = 30'd99999900;
  localparam logic [MAG_W-1:0] LIMIT_DEC2 = 30'd9999990;
  localparam logic [MAG_W-1:0] LIMIT_DEC3 = 30'd999999;

  // Decimal counts
  localparam logic [1:0] DEC_0 = 2'd0;
  localparam logic [1:0] DEC_1 = 2'd1;
  localparam logic [1:0] DEC_2 = 2'd2;
  localparam logic [1:0] DEC_3 = 2'd3;

  // Field lengths
  localparam logic [LEN_W-1:0] LEN_INT   = 3'd6;
  localparam logic [LEN_W-1:0] LEN_POINT = 3'd7;

  // Characters
  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_POINT = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;

  typedef logic [1:0] dec_t;

  typedef struct packed {
    logic [MAG_W-1:0]  magnitude;
    logic              negative;
    logic [MODE_W-1:0] decimals_mode;
    logic              allow_negative;
  } dnf_in_t;

  // Word handed along the conversion chain
  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [MAG_W-1:0] bin;
    dec_t             dec;
    logic             blank;
  } dnf_stage_t;

  typedef struct packed {
    logic [FIELD-1:0][CHAR_W-1:0] chars;   // index 0 is leftmost
    logic [LEN_W-1:0]             field_length;
    logic                         blanked;
  } dnf_res_t;

endpackage

`default_nettype wire

// ===== hdl/dnf_in_if.sv =====
// Input channel of the formatter: valid/ready handshake and one value word.
// Depends on dnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dnf_in_if import dnf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [MAG_W-1:0]  magnitude;
  logic              negative;
  logic [MODE_W-1:0] decimals_mode;
  logic              allow_negative;

  modport source (output valid, magnitude, negative, decimals_mode, allow_negative,
                  input ready);
  modport sink   (input valid, magnitude, negative, decimals_mode, allow_negative,
                  output ready);
endinterface

`default_nettype wire

// ===== hdl/dnf_out_if.sv =====
// Result channel of the formatter: valid/ready handshake and one field word.
// Depends on dnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface dnf_out_if import dnf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_0;
  logic [CHAR_W-1:0] char_1;
  logic [CHAR_W-1:0] char_2;
  logic [CHAR_W-1:0] char_3;
  logic [CHAR_W-1:0] char_4;
  logic [CHAR_W-1:0] char_5;
  logic [CHAR_W-1:0] char_6;
  logic [LEN_W-1:0]  field_length;
  logic              blanked;

  modport source (output valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6,
                  field_length, blanked, input ready);
  modport sink   (input valid, char_0, char_1, char_2, char_3, char_4, char_5, char_6,
                  field_length, blanked, output ready);
endinterface

`default_nettype wire

// ===== hdl/dnf_front.sv =====
// Entry stage: range checks, decimal count selection and blanking decision.
// Depends on dnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnf_front import dnf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dnf_in_t    in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output dnf_stage_t out_word
);

  logic       valid_r;
  dnf_stage_t word_r;
  dnf_stage_t word_nxt;
  logic       over0, over1, over2, over3;
  dec_t       dec;
  logic       reject;

  // Compare the unrounded magnitude against each limit
  assign over0 = in_word.magnitude > LIMIT_DEC0;
  assign over1 = in_word.magnitude > LIMIT_DEC1;
  assign over2 = in_word.magnitude > LIMIT_DEC2;
  assign over3 = in_word.magnitude > LIMIT_DEC3;

  // Pick decimals and decide on a blank field
  always_comb begin
    dec    = DEC_0;
    reject = 1'b0;
    case (in_word.decimals_mode)
      MODE_DEC0: begin
        dec    = DEC_0;
        reject = over0;
      end
      MODE_DEC1: begin
        dec    = DEC_1;
        reject = over1;
      end
      MODE_DEC2: begin
        dec    = DEC_2;
        reject = over2;
      end
      MODE_DEC3: begin
        dec    = DEC_3;
        reject = over3;
      end
      MODE_AUTO: begin
        if (!over3) begin
          dec = DEC_3;
        end else if (!over2) begin
          dec = DEC_2;
        end else if (!over1) begin
          dec = DEC_1;
        end else begin
          dec    = DEC_0;
          reject = over0;
        end
      end
      default: begin
        dec    = DEC_0;
        reject = 1'b1;
      end
    endcase
    if (in_word.negative && !in_word.allow_negative) begin
      reject = 1'b1;
    end
  end

  // Clear the value on a blank so the BCD chain never overflows
  always_comb begin
    word_nxt.bcd   = '0;
    word_nxt.bin   = reject ? '0 : in_word.magnitude;
    word_nxt.dec   = dec;
    word_nxt.blank = reject;
  end

  assign in_ready = !valid_r || out_ready;

  // Hold the word until the first cell takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

// ===== hdl/dnf_cell.sv =====
// One binary-to-BCD cell: adjust every digit, then shift in the next bit.
// Depends on dnf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module dnf_cell import dnf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dnf_stage_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output dnf_stage_t out_word
);

  logic             valid_r;
  dnf_stage_t       word_r;
  dnf_stage_t       word_nxt;
  logic [BCD_W-1:0] adj;

  // Add three to every digit of five or more
  always_comb begin
    for (int k = 0; k < DIGITS; k++) begin
      adj[4*k +: 4] = (in_word.bcd[4*k +: 4] >= 4'd5) ?
                      in_word.bcd[4*k +: 4] + 4'd3 : in_word.bcd[4*k +: 4];
    end
  end

  // Move the top binary bit into the BCD register
  always_comb begin
    word_nxt       = in_word;
    word_nxt.bcd   = {adj[BCD_W-2:0], in_word.bin[MAG_W-1]};
    word_nxt.bin   = {in_word.bin[MAG_W-2:0], 1'b0};
  end

  assign in_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

`default_nettype wire

// ===== hdl/dnf_format.sv =====
// Output stage: decimal rounding, leading-zero blanking and ASCII field build.
// Depends on dnf_pkg; holds the result register.
`timescale 1ns / 1ps
`default_nettype none

module dnf_format import dnf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dnf_stage_t in_word,
  output logic       out_valid,
  input  logic       out_ready,
  output dnf_res_t   out_word
);

  logic                         valid_r;
  dnf_res_t                     res_r;
  dnf_res_t                     res_nxt;
  logic [SHOWN*4-1:0]           kept;
  logic [3:0]                   rnd;
  logic                         carry;
  logic [SHOWN-1:0][3:0]        rd;
  logic                         above;
  logic [SHOWN-1:0]             shown;
  logic [SHOWN-1:0][CHAR_W-1:0] asc;

  // Select the six kept digits and the first dropped one, zero when none is dropped
  always_comb begin
    kept = in_word.bcd[SHOWN*4-1:0];
    rnd  = 4'd0;
    case (in_word.dec)
      DEC_0: begin
        kept = in_word.bcd[BCD_W-1:12];
        rnd  = in_word.bcd[11:8];
      end
      DEC_1: begin
        kept = in_word.bcd[BCD_W-5:8];
        rnd  = in_word.bcd[7:4];
      end
      DEC_2: begin
        kept = in_word.bcd[BCD_W-9:4];
        rnd  = in_word.bcd[3:0];
      end
      default: begin
        kept = in_word.bcd[SHOWN*4-1:0];
        rnd  = 4'd0;
      end
    endcase
  end

  // Round half up with a decimal carry chain
  always_comb begin
    carry = (rnd >= 4'd5);
    for (int i = 0; i < SHOWN; i++) begin
      if (carry) begin
        if (kept[4*i +: 4] == 4'd9) begin
          rd[i] = 4'd0;
        end else begin
          rd[i] = kept[4*i +: 4] + 4'd1;
          carry = 1'b0;
        end
      end else begin
        rd[i] = kept[4*i +: 4];
      end
    end
  end

  // Show a digit once a nonzero digit stands at or above it, or at or below the units
  always_comb begin
    above = 1'b0;
    for (int i = SHOWN - 1; i >= 0; i--) begin
      above    = above || (rd[i] != 4'd0);
      shown[i] = above || (i <= int'(in_word.dec));
      asc[i]   = shown[i] ? (CHAR_ZERO | {4'h0, rd[i]}) : CHAR_SPACE;
    end
  end

  // Place digits and the point, right-justified
  always_comb begin
    res_nxt.chars        = {FIELD{CHAR_SPACE}};
    res_nxt.chars[6]     = CHAR_NUL;
    res_nxt.field_length = LEN_INT;
    res_nxt.blanked      = in_word.blank;
    if (in_word.dec != DEC_0) begin
      res_nxt.field_length = LEN_POINT;
      for (int i = 0; i < SHOWN; i++) begin
        if (i < int'(in_word.dec)) begin
          res_nxt.chars[6-i] = asc[i];
        end else begin
          res_nxt.chars[5-i] = asc[i];
        end
      end
      case (in_word.dec)
        DEC_1:   res_nxt.chars[5] = CHAR_POINT;
        DEC_2:   res_nxt.chars[4] = CHAR_POINT;
        default: res_nxt.chars[3] = CHAR_POINT;
      endcase
    end else begin
      for (int i = 0; i < SHOWN; i++) begin
        res_nxt.chars[5-i] = asc[i];
      end
    end
    if (in_word.blank) begin
      res_nxt.chars        = {FIELD{CHAR_SPACE}};
      res_nxt.chars[6]     = CHAR_NUL;
      res_nxt.field_length = LEN_INT;
    end
  end

  assign in_ready = !valid_r || out_ready;

  // Hold the result until the receiver takes it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = res_r;

endmodule

`default_nettype wire

// ===== hdl/display_number_formatter.sv =====
// Display number formatter: turns a magnitude in thousandths plus a sign flag
// into a right-justified ASCII field for a six-digit display line.
// Channels: in_ch takes one value word per valid/ready handshake; out_ch
// gives one field word (seven characters, length, blank flag) per input word.
// Pipeline: 32 register stages - one check stage, a chain of 30 binary-to-BCD
// cells (one magnitude bit each), and one rounding and output stage.
// Throughput: one word per cycle while out_ch.ready is high; every stage holds
// one word, passing it onward on each clock when the next stage is empty or moving.
// Stall: when out_ch.ready is low the result holds in the output register;
// empty stages further up still fill, so input is taken until the chain is
// full, then in_ch.ready drops.
// Reset: rst_n (synchronous, active low) empties every stage; no result is
// pending afterwards and the block takes input on the next cycle.
// Depends on dnf_pkg, dnf_in_if, dnf_out_if, dnf_front, dnf_cell, dnf_format.
`timescale 1ns / 1ps
`default_nettype none

module display_number_formatter import dnf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  dnf_in_if.sink    in_ch,
  dnf_out_if.source out_ch
);

  dnf_in_t    in_word;
  dnf_res_t   res_word;
  logic       stg_valid [MAG_W+1];
  logic       stg_ready [MAG_W+1];
  dnf_stage_t stg_word  [MAG_W+1];

  // Pack the input word
  always_comb begin
    in_word.magnitude      = in_ch.magnitude;
    in_word.negative       = in_ch.negative;
    in_word.decimals_mode  = in_ch.decimals_mode;
    in_word.allow_negative = in_ch.allow_negative;
  end

  dnf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .in_word   (in_word),
    .out_valid (stg_valid[0]),
    .out_ready (stg_ready[0]),
    .out_word  (stg_word[0])
  );

  // Conversion chain, one magnitude bit per cell
  for (genvar g = 0; g < MAG_W; g++) begin : g_cell
    dnf_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_ready  (stg_ready[g]),
      .in_word   (stg_word[g]),
      .out_valid (stg_valid[g+1]),
      .out_ready (stg_ready[g+1]),
      .out_word  (stg_word[g+1])
    );
  end

  dnf_format u_format (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (stg_valid[MAG_W]),
    .in_ready  (stg_ready[MAG_W]),
    .in_word   (stg_word[MAG_W]),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_word  (res_word)
  );

  // Unpack the result word
  assign out_ch.char_0       = res_word.chars[0];
  assign out_ch.char_1       = res_word.chars[1];
  assign out_ch.char_2       = res_word.chars[2];
  assign out_ch.char_3       = res_word.chars[3];
  assign out_ch.char_4       = res_word.chars[4];
  assign out_ch.char_5       = res_word.chars[5];
  assign out_ch.char_6       = res_word.chars[6];
  assign out_ch.field_length = res_word.field_length;
  assign out_ch.blanked      = res_word.blanked;

endmodule

`default_nettype wire

// ===== hdl/dnf_checker.sv =====
// Port-level checks of display_number_formatter, attached by bind.
// Depends on dnf_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module dnf_checker import dnf_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [CHAR_W-1:0] char_0,
  input logic [CHAR_W-1:0] char_1,
  input logic [CHAR_W-1:0] char_2,
  input logic [CHAR_W-1:0] char_3,
  input logic [CHAR_W-1:0] char_4,
  input logic [CHAR_W-1:0] char_5,
  input logic [CHAR_W-1:0] char_6,
  input logic [LEN_W-1:0]  field_length,
  input logic              blanked
);

  // Reset empties the chain
  `DNF_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid)

  // A free output stage lets every stage above it move
  `DNF_ASSERT(a_ready_chain, clk, rst_n, (!out_valid || out_ready) |-> in_ready)

  // A stalled word holds its field
  `DNF_ASSERT(a_stall_hold, clk, rst_n, (out_valid && !out_ready) |=> (out_valid && $stable(char_0) && $stable(char_3) && $stable(char_6) && $stable(field_length) && $stable(blanked)))

  // A blank field is six spaces
  `DNF_ASSERT(a_blank_field, clk, rst_n, (out_valid && blanked) |-> (char_0 == CHAR_SPACE && char_1 == CHAR_SPACE && char_2 == CHAR_SPACE && char_3 == CHAR_SPACE && char_4 == CHAR_SPACE && char_5 == CHAR_SPACE && char_6 == CHAR_NUL && field_length == LEN_INT))

  // The last character of a shown number with a point is always a digit
  `DNF_ASSERT(a_last_digit, clk, rst_n, (out_valid && !blanked && field_length == LEN_POINT) |-> (char_6 >= CHAR_ZERO && char_6 <= (CHAR_ZERO + 8'd9)))

endmodule

bind display_number_formatter dnf_checker u_dnf_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .char_0       (out_ch.char_0),
  .char_1       (out_ch.char_1),
  .char_2       (out_ch.char_2),
  .char_3       (out_ch.char_3),
  .char_4       (out_ch.char_4),
  .char_5       (out_ch.char_5),
  .char_6       (out_ch.char_6),
  .field_length (out_ch.field_length),
  .blanked      (out_ch.blanked)
);

`default_nettype wire

// ===== dv/dnf_checker.sv =====
// Scoreboard of the display number formatter: watches both channels, predicts
// each formatted field from the accepted value word and compares the fields.
// Depends on dnf_pkg, dnf_in_if and dnf_out_if.
`timescale 1ns / 1ps

module dnf_scoreboard import dnf_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  dnf_in_if    in_ch,
  dnf_out_if   out_ch,
  output int   fail_count,
  output int   fields_pending,
  output int   fields_checked,
  output int   blanks_checked
);

  dnf_res_t expected_fields[$];

  initial begin
    fail_count     = 0;
    fields_pending = 0;
    fields_checked = 0;
    blanks_checked = 0;
  end

  // Largest unrounded magnitude shown with the given decimals
  function automatic logic [MAG_W-1:0] max_shown(input dec_t dec);
    case (dec)
      DEC_0:   return LIMIT_DEC0;
      DEC_1:   return LIMIT_DEC1;
      DEC_2:   return LIMIT_DEC2;
      default: return LIMIT_DEC3;
    endcase
  endfunction

  // Compute the field the formatter should give for one value word
  function automatic dnf_res_t format_field(input dnf_in_t w);
    dnf_res_t    f;
    dec_t        dec;
    logic        fits;
    int unsigned unit;
    int unsigned scale;
    int unsigned scaled;
    int unsigned ipart;
    int unsigned fpart;
    int unsigned pos;
    int          n;
    f.chars            = {FIELD{CHAR_SPACE}};
    f.chars[FIELD-1]   = CHAR_NUL;
    f.field_length     = LEN_INT;
    f.blanked          = 1'b1;
    dec  = DEC_0;
    fits = 1'b1;
    // Blank a negative value unless its magnitude may be shown
    if (w.negative && !w.allow_negative) return f;
    case (w.decimals_mode)
      MODE_AUTO: begin
        if (w.magnitude <= LIMIT_DEC3) dec = DEC_3;
        else if (w.magnitude <= LIMIT_DEC2) dec = DEC_2;
        else if (w.magnitude <= LIMIT_DEC1) dec = DEC_1;
        else if (w.magnitude <= LIMIT_DEC0) dec = DEC_0;
        else fits = 1'b0;
      end
      MODE_DEC0, MODE_DEC1, MODE_DEC2, MODE_DEC3: begin
        dec  = dec_t'(w.decimals_mode);
        fits = (w.magnitude <= max_shown(dec));
      end
      default: fits = 1'b0;
    endcase
    if (!fits) return f;
    // Round half up from thousandths to the chosen decimals
    unit = 1;
    repeat (int'(DEC_3) - int'(dec)) unit = unit * 10;
    scale = 1;
    repeat (int'(dec)) scale = scale * 10;
    scaled = (int'(w.magnitude) + unit / 2) / unit;
    ipart  = scaled / scale;
    fpart  = scaled % scale;
    // Fill digits from the right, point before the fraction
    f.chars = {FIELD{CHAR_SPACE}};
    pos = (dec != DEC_0) ? FIELD : FIELD - 1;
    for (n = 0; n < int'(dec); n++) begin
      pos = pos - 1;
      f.chars[pos] = CHAR_ZERO + CHAR_W'(fpart % 10);
      fpart = fpart / 10;
    end
    if (dec != DEC_0) begin
      pos = pos - 1;
      f.chars[pos] = CHAR_POINT;
    end
    do begin
      pos = pos - 1;
      f.chars[pos] = CHAR_ZERO + CHAR_W'(ipart % 10);
      ipart = ipart / 10;
    end while (ipart != 0 && pos > 0);
    if (dec == DEC_0) f.chars[FIELD-1] = CHAR_NUL;
    f.field_length = (dec == DEC_0) ? LEN_INT : LEN_POINT;
    f.blanked      = 1'b0;
    return f;
  endfunction

  task automatic check_field(input string name, input logic [CHAR_W-1:0] exp_v,
                             input logic [CHAR_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Predict on each accepted value word, compare on each accepted field word
  always @(posedge clk) begin
    dnf_in_t  word_in;
    dnf_res_t want;
    dnf_res_t got;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        word_in.magnitude      = in_ch.magnitude;
        word_in.negative       = in_ch.negative;
        word_in.decimals_mode  = in_ch.decimals_mode;
        word_in.allow_negative = in_ch.allow_negative;
        expected_fields.push_back(format_field(word_in));
      end
      if (out_ch.valid && out_ch.ready) begin
        got.chars[0]     = out_ch.char_0;
        got.chars[1]     = out_ch.char_1;
        got.chars[2]     = out_ch.char_2;
        got.chars[3]     = out_ch.char_3;
        got.chars[4]     = out_ch.char_4;
        got.chars[5]     = out_ch.char_5;
        got.chars[6]     = out_ch.char_6;
        got.field_length = out_ch.field_length;
        got.blanked      = out_ch.blanked;
        if (expected_fields.size() == 0) begin
          $error("field word with no value word pending");
          fail_count++;
        end else begin
          want = expected_fields.pop_front();
          for (int i = 0; i < FIELD; i++)
            check_field($sformatf("char_%0d", i), want.chars[i], got.chars[i]);
          check_field("field_length", CHAR_W'(want.field_length), CHAR_W'(got.field_length));
          check_field("blanked", CHAR_W'(want.blanked), CHAR_W'(got.blanked));
          fields_checked++;
          if (want.blanked) blanks_checked++;
        end
      end
      fields_pending = expected_fields.size();
    end
  end

endmodule

// ===== dv/tb_top.sv =====
// Top of the formatter testbench: clock, reset, value-word stimulus, result
// back-pressure and the verdict. Depends on dnf_pkg, dnf_in_if, dnf_out_if,
// display_number_formatter and dnf_scoreboard.
`timescale 1ns / 1ps

module tb_top;
  import dnf_pkg::*;

  // Decimals modes the block does not define
  localparam logic [MODE_W-1:0] MODE_RSV5 = 3'd5;
  localparam logic [MODE_W-1:0] MODE_RSV6 = 3'd6;
  localparam logic [MODE_W-1:0] MODE_RSV7 = 3'd7;

  localparam int RANDOM_WORDS = 2000;
  localparam int SEGMENTS     = 8;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;
  int   cycle_count;
  int   fail_count;
  int   fields_pending;
  int   fields_checked;
  int   blanks_checked;
  bit   tx_idle_on;
  bit   rx_idle_on;
  bit   long_hold_req;
  bit   long_hold_done;

  dnf_in_if  in_ch ();
  dnf_out_if out_ch ();

  display_number_formatter DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  dnf_scoreboard u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .fail_count     (fail_count),
    .fields_pending (fields_pending),
    .fields_checked (fields_checked),
    .blanks_checked (blanks_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // End the run if it hangs
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Test completed with failures");
    $finish;
  end

  // Drive result ready: random stalls, and one long hold-off on request
  initial begin
    out_ch.ready   = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      if (long_hold_req && !long_hold_done) begin
        out_ch.ready   = 1'b0;
        long_hold_done = 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
        out_ch.ready = 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_ch.ready = 1'b1;
      end
    end
  end

  function automatic logic [MAG_W-1:0] max_shown(input dec_t dec);
    case (dec)
      DEC_0:   return LIMIT_DEC0;
      DEC_1:   return LIMIT_DEC1;
      DEC_2:   return LIMIT_DEC2;
      default: return LIMIT_DEC3;
    endcase
  endfunction

  // Offer one value word and hold it until accepted
  task automatic send_word(input logic [MAG_W-1:0] mag, input logic neg,
                           input logic [MODE_W-1:0] mode, input logic allow_neg);
    @(negedge clk);
    in_ch.valid          = 1'b1;
    in_ch.magnitude      = mag;
    in_ch.negative       = neg;
    in_ch.decimals_mode  = mode;
    in_ch.allow_negative = allow_neg;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic pause_input(input int cycles);
    @(negedge clk);
    in_ch.valid = 1'b0;
    repeat (cycles - 1) @(posedge clk);
  endtask

  // Pick a magnitude class that reaches every mode, limit and rounding edge
  task automatic send_random_word();
    logic [MAG_W-1:0]  mag;
    logic [MODE_W-1:0] mode;
    logic              neg;
    logic              allow_neg;
    dec_t              dec;
    int unsigned       unit;
    int unsigned       q;
    dec = dec_t'($urandom_range(0, 3));
    case ($urandom_range(0, 7))
      0: mag = MAG_W'($urandom());
      1: mag = max_shown(dec) + MAG_W'($urandom_range(0, 6)) - MAG_W'(3);
      2: mag = MAG_W'($urandom_range(0, LIMIT_DEC3));
      3: mag = MAG_W'($urandom_range(0, LIMIT_DEC2));
      4: mag = MAG_W'($urandom_range(0, LIMIT_DEC1));
      5: mag = MAG_W'($urandom_range(0, LIMIT_DEC0));
      6: begin
        // Land on or just below a half-unit boundary
        unit = (dec == DEC_0) ? 1000 : (dec == DEC_1) ? 100 : 10;
        q    = $urandom_range(0, max_shown(dec) / unit - 1);
        mag  = MAG_W'(q * unit + unit / 2 - $urandom_range(0, 1));
      end
      default: mag = MAG_W'($urandom_range(0, 20));
    endcase
    if ($urandom_range(0, 7) != 0) mode = MODE_W'($urandom_range(MODE_DEC0, MODE_AUTO));
    else mode = MODE_W'($urandom_range(MODE_RSV5, MODE_RSV7));
    neg       = ($urandom_range(0, 2) == 0);
    allow_neg = ($urandom_range(0, 3) != 0);
    send_word(mag, neg, mode, allow_neg);
  endtask

  initial begin
    rst_n                = 1'b0;
    in_ch.valid          = 1'b0;
    in_ch.magnitude      = '0;
    in_ch.negative       = 1'b0;
    in_ch.decimals_mode  = MODE_DEC0;
    in_ch.allow_negative = 1'b0;
    tx_idle_on           = 1'b0;
    rx_idle_on           = 1'b0;
    long_hold_req        = 1'b0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed words: zero, each limit and one past it, rounding, sign, spare modes
    send_word('0, 1'b0, MODE_DEC0, 1'b0);
    send_word('0, 1'b0, MODE_DEC3, 1'b0);
    send_word('0, 1'b0, MODE_AUTO, 1'b0);
    send_word(LIMIT_DEC3, 1'b0, MODE_DEC3, 1'b0);
    send_word(LIMIT_DEC3 + 1, 1'b0, MODE_DEC3, 1'b0);
    send_word(LIMIT_DEC2, 1'b0, MODE_DEC2, 1'b0);
    send_word(LIMIT_DEC2 + 1, 1'b0, MODE_DEC2, 1'b0);
    send_word(LIMIT_DEC1, 1'b0, MODE_DEC1, 1'b0);
    send_word(LIMIT_DEC1 + 1, 1'b0, MODE_DEC1, 1'b0);
    send_word(LIMIT_DEC0, 1'b0, MODE_DEC0, 1'b0);
    send_word(LIMIT_DEC0 + 1, 1'b0, MODE_DEC0, 1'b0);
    send_word(LIMIT_DEC3 + 1, 1'b0, MODE_AUTO, 1'b0);
    send_word(LIMIT_DEC2 + 1, 1'b0, MODE_AUTO, 1'b0);
    send_word(LIMIT_DEC1 + 1, 1'b0, MODE_AUTO, 1'b0);
    send_word(LIMIT_DEC0, 1'b0, MODE_AUTO, 1'b0);
    send_word(LIMIT_DEC0 + 1, 1'b0, MODE_AUTO, 1'b0);
    send_word('1, 1'b1, MODE_AUTO, 1'b1);
    send_word(30'd1500, 1'b0, MODE_DEC0, 1'b0);
    send_word(30'd1449, 1'b0, MODE_DEC1, 1'b0);
    send_word(30'd12345, 1'b1, MODE_DEC2, 1'b0);
    send_word(30'd12345, 1'b1, MODE_DEC2, 1'b1);
    send_word(30'd12345, 1'b0, MODE_RSV5, 1'b0);
    send_word(30'd12345, 1'b0, MODE_RSV6, 1'b1);
    send_word(30'd12345, 1'b0, MODE_RSV7, 1'b0);

    // Random words in segments; the first fills the chain behind a long hold,
    // the last three run with no idling at all. Switch segments without waiting
    // for a clock so the last accepted word is never offered again.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      long_hold_req = (seg == 0);
      tx_idle_on    = (seg == 1) || (seg == 2) || (seg == 4);
      rx_idle_on    = (seg == 1) || (seg == 3) || (seg == 4);
      for (int n = 0; n < RANDOM_WORDS / SEGMENTS; n++) begin
        if (tx_idle_on && $urandom_range(0, 3) == 0) pause_input($urandom_range(1, 16));
        send_random_word();
      end
    end

    // Drain, then let the chain settle
    @(negedge clk);
    in_ch.valid = 1'b0;
    wait (fields_pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d formatted fields (%0d blank): all decimals modes, spare modes,",
             fields_checked, blanks_checked);
    $display("range limits, half-up rounding, sign handling and a full-chain stall.");
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
